/* src/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg: shared constants and types for the integer to ASCII converter
// Sizes, mode codes, character codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_CHARS   = 22;

    // One digit slot per octal digit covers every radix.
    localparam int NUM_DIGITS  = (VALUE_WIDTH + 2) / 3;
    localparam int OCT_WIDTH   = 3 * NUM_DIGITS;
    localparam int HEX_WIDTH   = 4 * NUM_DIGITS;

    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int REM_W  = $clog2(NUM_DIGITS + 1);
    localparam int NCHR_W = $clog2(MAX_CHARS + 1);

    localparam logic [1:0] ACT_SDEC = 2'd0;
    localparam logic [1:0] ACT_UDEC = 2'd1;
    localparam logic [1:0] ACT_OCT  = 2'd2;
    localparam logic [1:0] ACT_HEX  = 2'd3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] DIGIT_TEN  = 4'd10;

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic load;
        logic dabble;
        logic shift;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic load_neg;
        logic load_dec;
        logic dec;
        logic top_zero;
        logic out_free;
    } t_status;

endpackage

/* src/integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: 64-bit integer to ASCII digit stream
// Converts one number in signed decimal, unsigned decimal, octal or hex and
// sends its characters most significant first, one word per character.
// ----------------------------------------------------------------------------
// A number is taken only while the converter is idle and is worked on alone.
// After capture, a negative signed-decimal number sends its '-' first. Decimal
// modes then run a bit-serial binary-to-BCD pass; octal and hex
// digits are ready at capture. Leading zero digits are then dropped at one per
// cycle (up to 21), and the digits go out one per cycle when the output is not
// stalled. For a 20-digit decimal number the BCD pass dominates. The final
// character of each number carries last.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix import itoa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_value,
    input  logic [7:0]  i_letter_base,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last
);

    t_cmd    cmd;
    t_status status;

    itoa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    itoa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_letter_base (i_letter_base),
        .i_stall       (i_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_character   (o_character),
        .o_last        (o_last)
    );

endmodule

/* src/itoa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp: converter datapath
// Holds the magnitude, the digit array, the letter base and the output word.
// ----------------------------------------------------------------------------
module itoa_dp import itoa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [1:0]             i_action,
    input  logic [63:0]            i_value,
    input  logic [7:0]             i_letter_base,
    input  logic                   i_stall,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [7:0]             o_character,
    output logic                   o_last
);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] n_mag;
    t_digit                 r_dig [NUM_DIGITS];
    t_digit                 n_dig [NUM_DIGITS];
    t_digit                 adj   [NUM_DIGITS];
    logic [7:0]             r_letter;
    logic                   r_dec;
    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_last;
    logic [7:0]             n_char;

    logic [VALUE_WIDTH-1:0] in_v;
    logic [VALUE_WIDTH-1:0] in_neg_v;
    logic [OCT_WIDTH-1:0]   oct_v;
    logic [HEX_WIDTH-1:0]   hex_v;
    logic                   in_neg;
    logic                   in_dec;
    t_digit                 top;

    assign in_v     = i_value[VALUE_WIDTH-1:0];
    assign in_neg_v = -in_v;
    assign in_neg   = (i_action == ACT_SDEC) && in_v[VALUE_WIDTH-1];
    assign in_dec   = (i_action == ACT_SDEC) || (i_action == ACT_UDEC);
    assign oct_v    = OCT_WIDTH'(in_v);
    assign hex_v    = HEX_WIDTH'(in_v);
    assign top      = r_dig[NUM_DIGITS-1];

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
        n_mag = r_mag;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_dig[i] = r_dig[i];
        end
        if (i_cmd.load) begin
            n_mag = in_neg ? in_neg_v : in_v;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (i_action == ACT_OCT) begin
                    n_dig[i] = {1'b0, oct_v[3*i +: 3]};
                end else if (i_action == ACT_HEX) begin
                    n_dig[i] = hex_v[4*i +: 4];
                end else begin
                    n_dig[i] = '0;
                end
            end
        end else if (i_cmd.dabble) begin
            n_mag = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_dig[0] = {adj[0][2:0], r_mag[VALUE_WIDTH-1]};
            for (int i = 1; i < NUM_DIGITS; i++) begin
                n_dig[i] = {adj[i][2:0], adj[i-1][3]};
            end
        end else if (i_cmd.shift) begin
            n_dig[0] = '0;
            for (int i = 1; i < NUM_DIGITS; i++) begin
                n_dig[i] = r_dig[i-1];
            end
        end
    end

    always_comb begin
        if (i_cmd.emit_sign) begin
            n_char = CHAR_MINUS;
        end else if (top < DIGIT_TEN) begin
            n_char = CHAR_ZERO + {4'b0, top};
        end else begin
            n_char = r_letter + {4'b0, top} - {4'b0, DIGIT_TEN};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            r_dig[i] <= n_dig[i];
        end
        if (i_cmd.load) begin
            r_letter <= i_letter_base;
            r_dec    <= in_dec;
        end
        if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_char <= n_char;
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.load_neg = in_neg;
    assign o_status.load_dec = in_dec;
    assign o_status.dec      = r_dec;
    assign o_status.top_zero = (top == '0);
    assign o_status.out_free = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

/* src/itoa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl: converter sequencer
// Steps capture, sign, decimal conversion, zero skipping and digit output.
// ----------------------------------------------------------------------------
module itoa_ctrl import itoa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SIGN = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  n_rem;
    logic [NCHR_W-1:0] r_nchr;
    logic [NCHR_W-1:0] n_nchr;
    logic              last_char;

    assign last_char = (r_rem == REM_W'(1)) || (r_nchr == NCHR_W'(MAX_CHARS - 1));
    assign o_stall   = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_nchr  = r_nchr;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt  = CNT_W'(VALUE_WIDTH);
                    n_rem  = REM_W'(NUM_DIGITS);
                    n_nchr = '0;
                    if (i_status.load_neg) begin
                        n_state = ST_SIGN;
                    end else if (i_status.load_dec) begin
                        n_state = ST_CONV;
                    end else begin
                        n_state = ST_SKIP;
                    end
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_nchr  = r_nchr + NCHR_W'(1);
                    n_state = i_status.dec ? ST_CONV : ST_SKIP;
                end
            end
            ST_CONV: begin
                o_cmd.dabble = 1'b1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && (r_rem != REM_W'(1))) begin
                    o_cmd.shift = 1'b1;
                    n_rem = r_rem - REM_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    o_cmd.shift      = 1'b1;
                    o_cmd.last       = last_char;
                    n_rem  = r_rem - REM_W'(1);
                    n_nchr = r_nchr + NCHR_W'(1);
                    if (last_char) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_nchr <= n_nchr;
    end

endmodule

/* sim/tb_integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix: self-checking bench for the ASCII radix converter
// Sends directed and random numbers in all four modes. A built-in digit
// predictor queues the characters due for each number, and every output word
// is checked against them in order. Both sides idle at random, and the output
// is held off for a long stretch so that the converter backs up.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix;
    import itoa_pkg::*;

    localparam int LONG_HOLD      = 240;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int REPORT_LINES   = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_ascii_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [1:0]  i_action      = ACT_SDEC;
    logic [63:0] i_value       = 64'd0;
    logic [7:0]  i_letter_base = 8'd0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_character;
    logic        o_last;

    t_ascii_word digits_due[$];
    t_ascii_word oldest_due;
    int          mismatches   = 0;
    bit          idle_on      = 1'b1;
    int          rx_wait      = 0;
    int          hold_left    = 0;
    int          hold_ticket  = 0;
    int          hold_seen    = 0;
    int          quiet_cycles = 0;

    integer_to_ascii_radix i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_action      (i_action),
        .i_value       (i_value),
        .i_letter_base (i_letter_base),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LINES) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Queue the characters a number converts to, most significant first.
    function automatic void predict_digits(input logic [1:0] act, input logic [63:0] val,
                                           input logic [7:0] letter);
        logic [63:0] mask;
        logic [63:0] mag;
        logic [63:0] radix;
        logic [63:0] digit;
        logic [7:0]  rev[$];
        logic [7:0]  text[$];
        bit          negative;
        t_ascii_word w;
        mask     = (VALUE_WIDTH >= 64) ? '1 : (64'd1 << VALUE_WIDTH) - 64'd1;
        mag      = val & mask;
        negative = 1'b0;
        case (act)
            ACT_SDEC: begin
                radix = 64'd10;
                if (mag[VALUE_WIDTH-1]) begin
                    negative = 1'b1;
                    mag      = (~mag + 64'd1) & mask;
                end
            end
            ACT_UDEC: radix = 64'd10;
            ACT_OCT:  radix = 64'd8;
            default:  radix = 64'd16;
        endcase
        do begin
            digit = mag % radix;
            mag   = mag / radix;
            if (digit < 64'd10) begin
                rev.push_back(CHAR_ZERO + digit[7:0]);
            end else begin
                rev.push_back(letter + digit[7:0] - 8'd10);
            end
        end while (mag != 64'd0);
        if (negative) begin
            text.push_back(CHAR_MINUS);
        end
        while (rev.size() > 0) begin
            text.push_back(rev.pop_back());
        end
        while (text.size() > MAX_CHARS) begin
            void'(text.pop_back());
        end
        foreach (text[i]) begin
            w.ch   = text[i];
            w.last = (i == text.size() - 1);
            digits_due.push_back(w);
        end
    endfunction

    task automatic send_number(input logic [1:0] act, input logic [63:0] val,
                               input logic [7:0] letter);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_digits(act, val, letter);
        i_valid       <= 1'b1;
        i_action      <= act;
        i_value       <= val;
        i_letter_base <= letter;
        do @(posedge i_clk); while (o_stall !== 1'b0);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (digits_due.size() > 0);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        case ($urandom_range(0, 7))
            0: v = 64'($urandom_range(0, 999));
            1: v = 64'd1 << $urandom_range(0, 63);
            2: begin
                p = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3: v = 64'd0 - 64'($urandom_range(1, 1000));
            4: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            5: v = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
            6: v = '1 - 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 3))
            0:       return 8'h61;
            1:       return 8'h41;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_field_extremes();
        idle_on = 1'b1;
        send_number(ACT_SDEC, 64'd0, 8'h61);
        send_number(ACT_UDEC, 64'd0, 8'h61);
        send_number(ACT_OCT,  64'd0, 8'h61);
        send_number(ACT_HEX,  64'd0, 8'h61);
        send_number(ACT_SDEC, '1, 8'h61);
        send_number(ACT_UDEC, '1, 8'h61);
        send_number(ACT_OCT,  '1, 8'h41);
        send_number(ACT_HEX,  '1, 8'h41);
        send_number(ACT_SDEC, {1'b1, 63'd0}, 8'h61);
        send_number(ACT_SDEC, {1'b0, {63{1'b1}}}, 8'h61);
        send_number(ACT_SDEC, 64'd1, 8'h61);
        send_number(ACT_SDEC, 64'd0 - 64'd1000000000000000000, 8'h61);
        send_number(ACT_UDEC, 64'd10000000000000000000, 8'h61);
        send_number(ACT_UDEC, 64'd9999999999999999999, 8'h61);
        send_number(ACT_OCT,  {1'b1, 63'd0}, 8'h61);
        send_number(ACT_OCT,  64'o1234567012345670123456, 8'h61);
        send_number(ACT_HEX,  64'hFEDC_BA98_7654_3210, 8'h00);
        send_number(ACT_HEX,  64'hFEDC_BA98_7654_3210, 8'hFF);
        send_number(ACT_HEX,  64'h0000_0000_00AB_CDEF, 8'h41);
        send_number(ACT_HEX,  64'h1000_0000_0000_0000, 8'h61);
        send_number(ACT_HEX,  64'h0000_0000_0000_000F, 8'hF9);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (20) send_number(2'($urandom_range(0, 3)), pick_value(), pick_letter());
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_output_hold();
        idle_on     = 1'b0;
        hold_ticket <= hold_ticket + 1;
        repeat (12) send_number(2'($urandom_range(0, 3)), pick_value(), pick_letter());
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_mix();
        for (int n = 0; n < 230; n++) begin
            if (n % 46 == 0) begin
                idle_on = (n == 0) || ($urandom_range(0, 2) != 0);
            end
            send_number(2'($urandom_range(0, 3)), pick_value(), pick_letter());
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Check each output word, then choose the stall for the cycles ahead.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (digits_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%h last=%b",
                                          o_character, o_last));
            end else begin
                oldest_due = digits_due.pop_front();
                if (o_character !== oldest_due.ch) begin
                    report_mismatch($sformatf("character got %h want %h",
                                              o_character, oldest_due.ch));
                end
                if (o_last !== oldest_due.last) begin
                    report_mismatch($sformatf("last got %b want %b on char %h",
                                              o_last, oldest_due.last, oldest_due.ch));
                end
            end
            rx_wait = idle_on ? $urandom_range(0, 8) : 0;
        end
        if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_back_to_back();
        test_output_hold();
        test_random_mix();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && digits_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
src/itoa_pkg.sv
src/itoa_dp.sv
src/itoa_ctrl.sv
src/integer_to_ascii_radix.sv
sim/tb_integer_to_ascii_radix.sv
